FILE: rtl/core/dqs_pkg.sv
`default_nettype none

package dqs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_STAMP_WIDTH = 16;

    // Configuration register file.
    localparam int CAP_WIDTH       = 5;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LINE_CAPACITY = 1'b0,
        CFG_SERVE_POLICY  = 1'b1
    } t_cfg_reg;

    localparam logic CMD_JOIN         = 1'b0;
    localparam logic CMD_SERVE        = 1'b1;
    localparam logic KIND_JOIN        = 1'b0;
    localparam logic KIND_SERVED      = 1'b1;
    localparam logic POLICY_OLDEST    = 1'b0;
    localparam logic POLICY_ALTERNATE = 1'b1;
    localparam logic LINE_FIRST       = 1'b0;
    localparam logic LINE_SECOND      = 1'b1;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic valid;
        logic serve;
        logic line;
    } t_cmd_ctl;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SERVE = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/core/dqs_front.sv
`default_nettype none

module dqs_front #(
    parameter int ID_WIDTH = dqs_pkg::DEF_ID_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_cmd,
    input  wire logic                 i_line_select,
    input  wire logic [ID_WIDTH-1:0]  i_customer_id,
    output dqs_pkg::t_cmd_ctl         o_cmd_ctl,
    output logic [ID_WIDTH-1:0]       o_cmd_id,
    input  wire logic                 i_pop
);
    import dqs_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int FW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(CMDQ_DEPTH);

    logic                r_serve [CMDQ_DEPTH];
    logic                r_line  [CMDQ_DEPTH];
    logic [ID_WIDTH-1:0] r_id    [CMDQ_DEPTH];
    logic [PW-1:0]       r_wr_ptr;
    logic [PW-1:0]       r_rd_ptr;
    logic [FW-1:0]       r_fill;

    logic                push;
    logic                pop;
    logic                cls_serve;
    logic                cls_line;
    logic [ID_WIDTH-1:0] cls_id;

    assign o_in_stall = (r_fill == FULL_FILL);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_fill != '0);

    // A serve carries no queue or id; those fields are cleared so the back
    // end sees only what the command needs.
    always_comb begin
        cls_serve = (i_cmd == CMD_SERVE);
        cls_line  = cls_serve ? LINE_FIRST : i_line_select;
        cls_id    = cls_serve ? '0 : i_customer_id;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_serve[r_wr_ptr] <= cls_serve;
            r_line[r_wr_ptr]  <= cls_line;
            r_id[r_wr_ptr]    <= cls_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd_ctl.valid = (r_fill != '0);
        o_cmd_ctl.serve = r_serve[r_rd_ptr];
        o_cmd_ctl.line  = r_line[r_rd_ptr];
        o_cmd_id        = r_id[r_rd_ptr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/dqs_back.sv
`default_nettype none

module dqs_back #(
    parameter int QUEUE_DEPTH = dqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = dqs_pkg::DEF_ID_WIDTH,
    parameter int STAMP_WIDTH = dqs_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dqs_pkg::t_cmd_ctl                   i_cmd_ctl,
    input  wire logic [ID_WIDTH-1:0]                 i_cmd_id,
    output logic                                     o_pop,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dqs_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [dqs_pkg::CAP_WIDTH-1:0]       i_cfg_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_result_kind,
    output logic                                     o_join_accepted,
    output logic [ID_WIDTH-1:0]                      o_served_id,
    output logic                                     o_from_line,
    output logic [STAMP_WIDTH-1:0]                   o_arrival_stamp,
    output logic [STAMP_WIDTH-1:0]                   o_service_stamp,
    output logic                                     o_is_last
);
    import dqs_pkg::*;

    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    // Queue storage, one row per queue; only the head slot is ever read.
    logic [ID_WIDTH-1:0]    r_q_id    [2][QUEUE_DEPTH];
    logic [STAMP_WIDTH-1:0] r_q_stamp [2][QUEUE_DEPTH];
    logic [QW-1:0]          r_head    [2];
    logic [CW-1:0]          r_count   [2];
    logic [STAMP_WIDTH-1:0] r_arrival;
    logic [STAMP_WIDTH-1:0] r_service;
    logic                   r_turn_first;
    logic [CAP_WIDTH-1:0]   r_cap;
    logic                   r_policy;
    t_back_state            r_state;
    t_back_state            n_state;

    logic                   can_emit;
    logic                   any_queued;
    logic                   both_queued;
    logic                   last_entry;
    logic                   join_ok;
    logic [SW-1:0]          tail_sum;
    logic [QW-1:0]          tail;
    logic [STAMP_WIDTH-1:0] stamp_diff;
    logic                   first_older;
    logic                   which;
    logic                   do_join;
    logic                   do_emit;
    logic                   start_serve;

    assign o_cfg_ready = 1'b1;
    assign can_emit    = !o_out_valid || !i_out_stall;
    assign any_queued  = (r_count[0] != '0) || (r_count[1] != '0);
    assign both_queued = (r_count[0] != '0) && (r_count[1] != '0);
    assign last_entry  = ((r_count[0] == ONE_C) && (r_count[1] == '0))
                      || ((r_count[0] == '0) && (r_count[1] == ONE_C));

    // A join is accepted only while its queue's fill is below both the capacity register and the queue depth.
    always_comb begin
        join_ok = (CMPW'(r_count[i_cmd_ctl.line]) < CMPW'(r_cap))
               && (r_count[i_cmd_ctl.line] < DEPTH_C);
        tail_sum = SW'(r_head[i_cmd_ctl.line]) + SW'(r_count[i_cmd_ctl.line]);
        tail     = (tail_sum >= DEPTH_S) ? QW'(tail_sum - DEPTH_S) : QW'(tail_sum);
    end

    // Stamps wrap, so age is decided by the sign of the wrapped difference.
    always_comb begin
        stamp_diff  = r_q_stamp[0][r_head[0]] - r_q_stamp[1][r_head[1]];
        first_older = (stamp_diff == '0) || stamp_diff[STAMP_WIDTH-1];
        if (both_queued) begin
            if (r_policy == POLICY_OLDEST) begin
                which = first_older ? LINE_FIRST : LINE_SECOND;
            end else begin
                which = r_turn_first ? LINE_FIRST : LINE_SECOND;
            end
        end else begin
            which = (r_count[0] != '0) ? LINE_FIRST : LINE_SECOND;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_ctl.valid && i_cmd_ctl.serve && any_queued) begin
                    n_state = ST_SERVE;
                end
            end
            ST_SERVE: begin
                if (can_emit && last_entry) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        do_join     = 1'b0;
        do_emit     = 1'b0;
        start_serve = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_ctl.valid) begin
                    if (!i_cmd_ctl.serve) begin
                        do_join = can_emit;
                        o_pop   = can_emit;
                    end else begin
                        // A serve with both queues empty retires silently.
                        o_pop       = 1'b1;
                        start_serve = any_queued;
                    end
                end
            end
            ST_SERVE: begin
                do_emit = can_emit;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_join && join_ok) begin
            r_q_id[i_cmd_ctl.line][tail]    <= i_cmd_id;
            r_q_stamp[i_cmd_ctl.line][tail] <= r_arrival;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '{default: '0};
            r_count      <= '{default: '0};
            r_arrival    <= '0;
            r_service    <= '0;
            r_turn_first <= 1'b1;
            r_cap        <= CAP_RESET;
            r_policy     <= POLICY_OLDEST;
            r_state      <= ST_IDLE;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LINE_CAPACITY) begin
                    r_cap <= i_cfg_data;
                end else begin
                    r_policy <= i_cfg_data[0];
                end
            end
            if (do_join && join_ok) begin
                r_count[i_cmd_ctl.line] <= r_count[i_cmd_ctl.line] + 1'b1;
                r_arrival               <= r_arrival + 1'b1;
            end
            if (start_serve) begin
                r_turn_first <= 1'b1;
            end
            if (do_emit) begin
                r_head[which]  <= (r_head[which] == LAST_IDX) ? '0 : r_head[which] + 1'b1;
                r_count[which] <= r_count[which] - 1'b1;
                r_service      <= r_service + 1'b1;
                if (both_queued && (r_policy == POLICY_ALTERNATE)) begin
                    r_turn_first <= !r_turn_first;
                end
            end
            if (do_join || do_emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_join) begin
            o_result_kind   <= KIND_JOIN;
            o_join_accepted <= join_ok;
            o_served_id     <= '0;
            o_from_line     <= LINE_FIRST;
            o_arrival_stamp <= '0;
            o_service_stamp <= '0;
            o_is_last       <= 1'b1;
        end else if (do_emit) begin
            o_result_kind   <= KIND_SERVED;
            o_join_accepted <= 1'b0;
            o_served_id     <= r_q_id[which][r_head[which]];
            o_from_line     <= which;
            o_arrival_stamp <= r_q_stamp[which][r_head[which]];
            o_service_stamp <= r_service;
            o_is_last       <= last_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= DEPTH_C) && (r_count[1] <= DEPTH_C))
        else $error("queue fill exceeds its depth");

    a_serve_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SERVE) |-> any_queued)
        else $error("serve phase entered with both queues empty");

    a_drain_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_emit && last_entry) |=> (r_state == ST_IDLE) && !any_queued)
        else $error("last served record left entries behind");

    a_join_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_join |=> o_out_valid && o_is_last && (o_result_kind == KIND_JOIN))
        else $error("join acknowledgement not marked as last");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dual_queue_oldest_or_alternate_server.sv
`default_nettype none

// Two bounded customer queues with a join/serve command stream. A join in the
// back end yields one acknowledgement; a serve first enters the serve state and
// then drains both queues at one served record per cycle while the output is
// not stalled, and a serve with both queues empty retires with no record. The
// drain rate is set by the single dequeue per cycle of the back end feeding one
// output register. A two-entry command queue sits between input and back end,
// so up to two new commands are taken while a drain is in progress.
// Configuration writes are always taken and must only be made while no command
// is in flight.
module dual_queue_oldest_or_alternate_server #(
    parameter int QUEUE_DEPTH = dqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = dqs_pkg::DEF_ID_WIDTH,
    parameter int STAMP_WIDTH = dqs_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_cmd,
    input  wire logic                                i_line_select,
    input  wire logic [ID_WIDTH-1:0]                 i_customer_id,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dqs_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [dqs_pkg::CAP_WIDTH-1:0]       i_cfg_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_result_kind,
    output logic                                     o_join_accepted,
    output logic [ID_WIDTH-1:0]                      o_served_id,
    output logic                                     o_from_line,
    output logic [STAMP_WIDTH-1:0]                   o_arrival_stamp,
    output logic [STAMP_WIDTH-1:0]                   o_service_stamp,
    output logic                                     o_is_last
);
    import dqs_pkg::*;

    t_cmd_ctl            cmd_ctl;
    logic [ID_WIDTH-1:0] cmd_id;
    logic                cmd_pop;

    dqs_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_line_select (i_line_select),
        .i_customer_id (i_customer_id),
        .o_cmd_ctl     (cmd_ctl),
        .o_cmd_id      (cmd_id),
        .i_pop         (cmd_pop)
    );

    dqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_ctl       (cmd_ctl),
        .i_cmd_id        (cmd_id),
        .o_pop           (cmd_pop),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_join_accepted (o_join_accepted),
        .o_served_id     (o_served_id),
        .o_from_line     (o_from_line),
        .o_arrival_stamp (o_arrival_stamp),
        .o_service_stamp (o_service_stamp),
        .o_is_last       (o_is_last)
    );

endmodule

`default_nettype wire

FILE: sim/tb_dual_queue_oldest_or_alternate_server.sv
`timescale 1ns / 100ps

module tb_dual_queue_oldest_or_alternate_server;
    import dqs_pkg::*;

    localparam int DEPTH         = DEF_QUEUE_DEPTH;
    localparam int IDW           = DEF_ID_WIDTH;
    localparam int SW            = DEF_STAMP_WIDTH;
    localparam int PTR_W         = $clog2(DEF_QUEUE_DEPTH);
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic           kind;
        logic           accepted;
        logic [IDW-1:0] id;
        logic           line;
        logic [SW-1:0]  arrival;
        logic [SW-1:0]  service;
        logic           last;
    } t_result;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_in_valid      = 1'b0;
    logic                       i_cmd           = CMD_JOIN;
    logic                       i_line_select   = LINE_FIRST;
    logic [IDW-1:0]             i_customer_id   = '0;
    logic                       i_cfg_valid     = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index     = CFG_LINE_CAPACITY;
    logic [CAP_WIDTH-1:0]       i_cfg_data      = '0;
    logic                       i_out_stall     = 1'b0;
    logic                       o_in_stall;
    logic                       o_cfg_ready;
    logic                       o_out_valid;
    logic                       o_result_kind;
    logic                       o_join_accepted;
    logic [IDW-1:0]             o_served_id;
    logic                       o_from_line;
    logic [SW-1:0]              o_arrival_stamp;
    logic [SW-1:0]              o_service_stamp;
    logic                       o_is_last;

    // Predicted state of the two queues and the counters.
    logic [IDW-1:0]       held_id    [2][DEPTH];
    logic [SW-1:0]        held_stamp [2][DEPTH];
    logic [PTR_W-1:0]     front      [2];
    int                   fill       [2];
    logic [SW-1:0]        arrival_count;
    logic [SW-1:0]        service_count;
    logic [CAP_WIDTH-1:0] capacity;
    logic                 policy;
    t_result              awaited[$];

    t_idle_mode idle_mode    = IDLE_NONE;
    int         hold_request = 0;
    int         hold_left    = 0;
    int         mismatches   = 0;

    dual_queue_oldest_or_alternate_server i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_line_select   (i_line_select),
        .i_customer_id   (i_customer_id),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_join_accepted (o_join_accepted),
        .o_served_id     (o_served_id),
        .o_from_line     (o_from_line),
        .o_arrival_stamp (o_arrival_stamp),
        .o_service_stamp (o_service_stamp),
        .o_is_last       (o_is_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic add_expected(input t_result r);
        awaited.insert(awaited.size(), r);
    endtask

    task automatic predict_join(input logic line, input logic [IDW-1:0] id);
        int               limit;
        logic [PTR_W-1:0] slot;
        t_result          r;
        limit = (capacity < DEPTH) ? capacity : DEPTH;
        r = '0;
        r.kind = KIND_JOIN;
        r.last = 1'b1;
        if (fill[line] < limit) begin
            slot = PTR_W'(front[line] + fill[line]);
            held_id[line][slot] = id;
            held_stamp[line][slot] = arrival_count;
            fill[line]++;
            arrival_count++;
            r.accepted = 1'b1;
        end
        add_expected(r);
    endtask

    task automatic predict_drain();
        logic          first_turn;
        logic          pick;
        logic [SW-1:0] gap;
        t_result       r;
        first_turn = 1'b1;
        while (fill[0] != 0 || fill[1] != 0) begin
            if (fill[0] != 0 && fill[1] != 0) begin
                if (policy == POLICY_OLDEST) begin
                    // Wrapped difference: the first front is older when the top bit is set or the difference is zero.
                    gap = held_stamp[0][front[0]] - held_stamp[1][front[1]];
                    pick = (gap == '0 || gap[SW-1]) ? LINE_FIRST : LINE_SECOND;
                end else begin
                    pick = first_turn ? LINE_FIRST : LINE_SECOND;
                    first_turn = ~first_turn;
                end
            end else begin
                pick = (fill[0] != 0) ? LINE_FIRST : LINE_SECOND;
            end
            r.kind = KIND_SERVED;
            r.accepted = 1'b0;
            r.id = held_id[pick][front[pick]];
            r.line = pick;
            r.arrival = held_stamp[pick][front[pick]];
            r.service = service_count;
            service_count++;
            front[pick]++;
            fill[pick]--;
            r.last = (fill[0] == 0 && fill[1] == 0);
            add_expected(r);
        end
    endtask

    // Called just after a falling edge; returns just after the falling edge that
    // follows the transfer, with valid still high.
    task automatic send_item(input logic cmd, input logic line, input logic [IDW-1:0] id);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 73) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 21)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_line_select <= line;
        i_customer_id <= id;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_JOIN) begin
            predict_join(line, id);
        end else begin
            predict_drain();
        end
        @(negedge i_clk);
    endtask

    // A serve of empty queues yields nothing, so the settle time covers it.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg which, input logic [CAP_WIDTH-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (which == CFG_LINE_CAPACITY) begin
            capacity = value;
        end else begin
            policy = value[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idle_mode == IDLE_RECEIVER) begin
            i_out_stall <= ($urandom_range(99) < 73);
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_stall <= ($urandom_range(99) < 21);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_result_kind, o_join_accepted, o_served_id, o_from_line,
                   o_arrival_stamp, o_service_stamp, o_is_last};
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: kind=%0d acc=%0d id=%h line=%0d arr=%h svc=%h last=%0d",
                             got.kind, got.accepted, got.id, got.line,
                             got.arrival, got.service, got.last);
                end
            end else begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.accepted !== want.accepted ||
                    got.id !== want.id || got.line !== want.line ||
                    got.arrival !== want.arrival || got.service !== want.service ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: exp kind=%0d acc=%0d id=%h line=%0d arr=%h svc=%h last=%0d",
                                 want.kind, want.accepted, want.id, want.line,
                                 want.arrival, want.service, want.last);
                        $display("          got kind=%0d acc=%0d id=%h line=%0d arr=%h svc=%h last=%0d",
                                 got.kind, got.accepted, got.id, got.line,
                                 got.arrival, got.service, got.last);
                    end
                end
            end
        end
    end

    task automatic test_empty_serve();
        idle_mode = IDLE_NONE;
        send_item(CMD_SERVE, LINE_SECOND, 16'hFFFF);
    endtask

    task automatic test_oldest_first();
        send_item(CMD_JOIN, LINE_FIRST, 16'h0000);
        send_item(CMD_JOIN, LINE_SECOND, 16'hFFFF);
        send_item(CMD_JOIN, LINE_SECOND, 16'h1234);
        send_item(CMD_JOIN, LINE_FIRST, 16'hFFFF);
        send_item(CMD_SERVE, LINE_FIRST, 16'h0000);
    endtask

    task automatic test_alternate_order();
        // Upper data bits are set on purpose; only bit zero selects the policy.
        write_register(CFG_SERVE_POLICY, 5'h1F);
        send_item(CMD_JOIN, LINE_SECOND, 16'hA5A5);
        send_item(CMD_JOIN, LINE_SECOND, 16'h5A5A);
        send_item(CMD_JOIN, LINE_FIRST, 16'h00FF);
        send_item(CMD_JOIN, LINE_SECOND, 16'hFF00);
        send_item(CMD_SERVE, LINE_SECOND, 16'h0F0F);
        send_item(CMD_JOIN, LINE_SECOND, 16'h7777);
        send_item(CMD_SERVE, LINE_FIRST, 16'hF0F0);
    endtask

    task automatic test_capacity_limits();
        write_register(CFG_LINE_CAPACITY, 5'd0);
        send_item(CMD_JOIN, LINE_FIRST, 16'h0001);
        send_item(CMD_JOIN, LINE_SECOND, 16'h0002);
        send_item(CMD_SERVE, LINE_FIRST, 16'h0000);
        write_register(CFG_LINE_CAPACITY, 5'd2);
        repeat (3) send_item(CMD_JOIN, LINE_SECOND, 16'($urandom_range(16'hFFFF)));
        // Capacity now below the fill of the second queue: its entries stay.
        write_register(CFG_LINE_CAPACITY, 5'd1);
        send_item(CMD_JOIN, LINE_SECOND, 16'h4321);
        send_item(CMD_JOIN, LINE_FIRST, 16'h8765);
        send_item(CMD_SERVE, LINE_SECOND, 16'h0000);
    endtask

    task automatic test_output_holdoff();
        write_register(CFG_LINE_CAPACITY, 5'd16);
        write_register(CFG_SERVE_POLICY, {4'b0000, POLICY_OLDEST});
        idle_mode = IDLE_NONE;
        hold_request = 80;
        repeat (10) begin
            send_item(CMD_JOIN, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        end
        send_item(CMD_SERVE, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        send_item(CMD_JOIN, LINE_FIRST, 16'($urandom_range(16'hFFFF)));
    endtask

    task automatic test_sender_pause();
        idle_mode = IDLE_NONE;
        repeat (5) begin
            send_item(CMD_JOIN, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        end
        wait_idle();
        send_item(CMD_SERVE, LINE_FIRST, 16'h0000);
        wait_idle();
        send_item(CMD_SERVE, LINE_SECOND, 16'h0000);
    endtask

    task automatic test_random_traffic(input logic [CAP_WIDTH-1:0] cap, input logic pol,
                                       input t_idle_mode mode, input int count);
        int                   sent;
        int                   burst;
        int                   choice;
        logic                 fixed_line;
        logic                 one_line;
        logic [CAP_WIDTH-1:0] pol_word;
        pol_word = CAP_WIDTH'($urandom);
        pol_word[0] = pol;
        write_register(CFG_LINE_CAPACITY, cap);
        write_register(CFG_SERVE_POLICY, pol_word);
        idle_mode = mode;
        sent = 0;
        while (sent < count) begin
            choice = $urandom_range(9);
            if (choice < 7) begin
                // A run of joins, often all on one queue, closed by a serve.
                burst = $urandom_range(1, 20);
                fixed_line = $urandom_range(1);
                one_line = ($urandom_range(2) == 0);
                repeat (burst) begin
                    send_item(CMD_JOIN, one_line ? fixed_line : 1'($urandom_range(1)),
                              16'($urandom_range(16'hFFFF)));
                end
                send_item(CMD_SERVE, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
                sent += burst + 1;
            end else if (choice < 9) begin
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                          16'($urandom_range(16'hFFFF)));
                sent++;
            end else begin
                wait_idle();
            end
        end
    endtask

    initial begin
        capacity = CAP_RESET;
        policy = POLICY_OLDEST;
        arrival_count = '0;
        service_count = '0;
        fill[0] = 0;
        fill[1] = 0;
        front[0] = '0;
        front[1] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_serve();
        test_oldest_first();
        test_alternate_order();
        test_capacity_limits();
        test_output_holdoff();
        test_sender_pause();
        test_random_traffic(5'd16, POLICY_OLDEST, IDLE_NONE, 40);
        test_random_traffic(5'd31, POLICY_ALTERNATE, IDLE_SENDER, 40);
        test_random_traffic(5'd3, POLICY_OLDEST, IDLE_RECEIVER, 30);
        test_random_traffic(5'd1, POLICY_ALTERNATE, IDLE_BOTH, 30);
        test_random_traffic(5'($urandom_range(2, 31)), POLICY_ALTERNATE, IDLE_BOTH, 30);

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
